// File: rtl/srt_pkg.sv
// Shared types and constants for the Snell refraction / Schlick reflectance block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package srt_pkg;

  // Internal fixed-point fraction bits of all inner quantities.
  localparam int IFB = 24;
  localparam logic [24:0] IONE = 25'd16777216;

  // Iterative quotient unit and square root pipeline lengths.
  localparam int DIV_STEPS   = 40;
  localparam int SQRT_STEPS  = 25;
  localparam int SQRT_W      = 50;

  // Largest index ratio, 16.0 in Q.24.
  localparam logic [39:0] RATIO_MAX = 40'h00_1000_0000;

  // Configuration register indexes and reset values.
  localparam logic [0:0]  REG_OUTSIDE   = 1'b0;
  localparam logic [0:0]  REG_INSIDE    = 1'b1;
  localparam logic [15:0] OUTSIDE_RESET = 16'd4096;
  localparam logic [15:0] INSIDE_RESET  = 16'd6144;

  // Reflectance of exactly one in Q1.14.
  localparam logic [14:0] REFL_ONE = 15'd16384;

  typedef enum logic [1:0] {
    CS_LOAD,
    CS_DIV,
    CS_MUL,
    CS_RUN
  } cfg_state_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] refr_x;
    logic signed [15:0] refr_y;
    logic signed [15:0] refr_z;
    logic               total_reflect;
    logic [14:0]        reflectance;
  } out_item_t;

  // Per-configuration quantities prepared by the front part.
  typedef struct packed {
    logic [28:0] ratio;
    logic [32:0] ratio2;
    logic [24:0] r0;
    logic        ext_gt;
  } coef_t;

  // Side data that travels beside the square root pipeline.
  typedef struct packed {
    logic               tir;
    logic signed [25:0] c;
    logic signed [29:0] rc;
    in_item_t           item;
  } sqrt_side_t;

endpackage

`default_nettype wire

// File: rtl/srt_if.sv
// Valid/ready channel interfaces for requests into and results out of the block.
// Depends on srt_pkg for the payload types.
`default_nettype none

interface srt_in_if import srt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/srt_front.sv
// Front part: index registers, iterative quotient unit for the index ratio and
// Schlick base term, and a two-entry request queue. Depends on srt_pkg.
`default_nettype none

module srt_front import srt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_ready,
  output logic       q_valid,
  output in_item_t   q_data,
  input  logic       q_pop,
  output coef_t      coef
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [15:0] ext_r, inn_r;
  cfg_state_t  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic [39:0] a_r, b_r;
  logic [15:0] rem_a_r;
  logic [16:0] rem_b_r;

  logic [15:0] inn_eff, diff;
  logic [16:0] div_b;
  logic [16:0] ta;
  logic [17:0] tb;
  logic        ge_a, ge_b;
  logic [28:0] ratio_sat;
  logic [57:0] ratio_sq;
  logic [49:0] q_sq;

  logic [28:0] ratio_r;
  logic [32:0] ratio2_r;
  logic [24:0] r0_r;

  in_item_t q_mem_r [2];
  logic     wr_ptr_r, rd_ptr_r;
  logic [1:0] q_cnt_r;
  logic     push, pop;

  // Index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= OUTSIDE_RESET;
      inn_r <= INSIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTSIDE: ext_r <= cfg_wdata;
        REG_INSIDE:  inn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Divisor and dividend terms; a zero inside index reads as one step.
  assign inn_eff = (inn_r == 16'd0) ? 16'd1 : inn_r;
  assign diff    = (ext_r > inn_eff) ? (ext_r - inn_eff) : (inn_eff - ext_r);
  assign div_b   = {1'b0, ext_r} + {1'b0, inn_eff};

  // One restoring quotient bit per cycle for both divisions.
  assign ta   = {rem_a_r, a_r[39]};
  assign ge_a = ta >= {1'b0, inn_eff};
  assign tb   = {rem_b_r, b_r[39]};
  assign ge_b = tb >= {1'b0, div_b};

  // Saturated ratio and the squares taken once per configuration.
  // The base quotient reaches exactly one when the outside index is zero.
  assign ratio_sat = (a_r > RATIO_MAX) ? RATIO_MAX[28:0] : a_r[28:0];
  assign ratio_sq  = 58'(ratio_sat) * 58'(ratio_sat);
  assign q_sq      = 50'(b_r[24:0]) * 50'(b_r[24:0]);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state; any register write restarts the computation.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_LOAD: state_nxt = CS_DIV;
      CS_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = CS_MUL;
      CS_MUL:  state_nxt = CS_RUN;
      CS_RUN:  state_nxt = CS_RUN;
      default: state_nxt = CS_LOAD;
    endcase
    if (cfg_we) state_nxt = CS_LOAD;
  end

  // Quotient datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (state_r)
        CS_LOAD: begin
          cnt_r   <= '0;
          a_r     <= {ext_r, 24'd0};
          b_r     <= {diff, 24'd0};
          rem_a_r <= '0;
          rem_b_r <= '0;
        end
        CS_DIV: begin
          cnt_r   <= cnt_r + CNT_W'(1);
          a_r     <= {a_r[38:0], ge_a};
          b_r     <= {b_r[38:0], ge_b};
          rem_a_r <= ge_a ? 16'(ta - {1'b0, inn_eff}) : ta[15:0];
          rem_b_r <= ge_b ? 17'(tb - {1'b0, div_b}) : tb[16:0];
        end
        CS_MUL: begin
          ratio_r  <= ratio_sat;
          ratio2_r <= ratio_sq[56:24];
          r0_r     <= q_sq[48:24];
        end
        default: ;
      endcase
    end
  end

  assign coef.ratio  = ratio_r;
  assign coef.ratio2 = ratio2_r;
  assign coef.r0     = r0_r;
  assign coef.ext_gt = ext_r > inn_eff;

  // Request queue between the input channel and the arithmetic pipeline.
  assign in_ready = (state_r == CS_RUN) && (q_cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = q_cnt_r != 2'd0;
  assign pop      = q_pop && q_valid;
  assign q_data   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/srt_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on srt_pkg.
`default_nettype none

module srt_sqrt import srt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [48:0] in_rad,
  input  sqrt_side_t  in_side,
  output logic        out_valid,
  output logic [24:0] out_root,
  output sqrt_side_t  out_side
);

  logic [SQRT_W-1:0] rem_r  [SQRT_STEPS];
  logic [SQRT_W-1:0] res_r  [SQRT_STEPS];
  sqrt_side_t        side_r [SQRT_STEPS];
  logic              vld_r  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQRT_W-1:0] rem_i, res_i, sum;
    sqrt_side_t        side_i;
    logic              vld_i;

    if (k == 0) begin : g_first
      assign rem_i  = SQRT_W'(in_rad);
      assign res_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign res_i  = res_r[k-1];
      assign side_i = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign sum = res_i + BIT;

    // One root bit: subtract the trial value when it fits.
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        if (rem_i >= sum) begin
          rem_r[k] <= rem_i - sum;
          res_r[k] <= (res_i >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_i;
          res_r[k] <= res_i >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = res_r[SQRT_STEPS-1][24:0];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/srt_back.sv
// Back part: incidence cosine, refraction and Schlick reflectance pipeline
// with output register. Depends on srt_pkg and srt_sqrt.
`default_nettype none

module srt_back import srt_pkg::*; #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  coef_t     coef,
  input  logic      q_valid,
  input  in_item_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  localparam int C_SH = (2 * VEC_FRAC_BITS >= IFB) ? 2 * VEC_FRAC_BITS - IFB : 0;
  localparam int C_SL = (2 * VEC_FRAC_BITS >= IFB) ? 0 : IFB - 2 * VEC_FRAC_BITS;
  localparam logic signed [63:0] C_MAX = 64'sd16777216;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7fff;
    if (v < -24'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic en;
  logic signed [29:0] ratio_s;

  // Stage registers.
  logic v1_r, v2_r, v3_r, v4_r, v6_r, v7_r, v8_r, v9_r, v10_r, vo_r;
  in_item_t it1_r, it2_r, it3_r, it4_r, it6_r;
  logic signed [31:0] px1_r, py1_r, pz1_r;
  logic signed [25:0] c2_r, c3_r, c4_r;
  logic [24:0] cos2_3_r;
  logic signed [29:0] rc3_r, rc4_r;
  logic [33:0] sin2_4_r;
  logic signed [30:0] coef6_r;
  logic [25:0] x6_r, x7_r, x8_r;
  logic tir6_r, tir7_r, tir8_r, tir9_r, tir10_r;
  logic signed [46:0] pnx7_r, pny7_r, pnz7_r;
  logic signed [45:0] pdx7_r, pdy7_r, pdz7_r;
  logic [26:0] x2_7_r;
  logic [28:0] x4_8_r;
  logic [29:0] x5_9_r;
  logic [30:0] t10_r;
  logic signed [15:0] rx8_r, ry8_r, rz8_r, rx9_r, ry9_r, rz9_r, rx10_r, ry10_r, rz10_r;
  out_item_t out_r;

  // Combinational terms.
  logic signed [31:0] px, py, pz;
  logic signed [33:0] dot;
  logic signed [63:0] negw, cw;
  logic signed [25:0] c_nxt;
  logic signed [51:0] cc;
  logic signed [55:0] rcp;
  logic [24:0] one_m;
  logic [57:0] sp;
  logic        tir5;
  logic [48:0] rad5;
  sqrt_side_t  side5, sside;
  logic        sv;
  logic [24:0] root;
  logic signed [26:0] kk;
  logic signed [26:0] xs;
  logic signed [46:0] pnx, pny, pnz;
  logic signed [45:0] pdx, pdy, pdz;
  logic [51:0] x2p;
  logic signed [47:0] accx, accy, accz;
  logic [53:0] x4p;
  logic [54:0] x5p;
  logic [24:0] om;
  logic [54:0] tp;
  logic [31:0] rr;
  logic [21:0] rq;
  logic [14:0] refl;

  // The whole pipeline advances unless the output holds an untaken result.
  assign en      = !vo_r || out_ready;
  assign q_pop   = en && q_valid;
  assign ratio_s = $signed({1'b0, coef.ratio});

  // Cosine: component products, dot product, scaling and clamp.
  assign px   = $signed(q_data.dir_x) * $signed(q_data.norm_x);
  assign py   = $signed(q_data.dir_y) * $signed(q_data.norm_y);
  assign pz   = $signed(q_data.dir_z) * $signed(q_data.norm_z);
  assign dot  = 34'(px1_r) + 34'(py1_r) + 34'(pz1_r);
  assign negw = -64'(dot);
  assign cw   = (negw >>> C_SH) <<< C_SL;

  always_comb begin
    if (cw > C_MAX)       c_nxt = 26'sd16777216;
    else if (cw < -C_MAX) c_nxt = -26'sd16777216;
    else                  c_nxt = cw[25:0];
  end

  // Squared cosine, ratio times cosine, and the squared sine of the refraction.
  assign cc    = c2_r * c2_r;
  assign rcp   = ratio_s * c2_r;
  assign one_m = IONE - cos2_3_r;
  assign sp    = 58'(coef.ratio2) * 58'(one_m);

  // Total internal reflection test and square root radicand.
  always_comb begin
    tir5       = sin2_4_r > 34'(IONE);
    rad5       = tir5 ? '0 : {25'(IONE - sin2_4_r[24:0]), 24'd0};
    side5.tir  = tir5;
    side5.c    = c4_r;
    side5.rc   = rc4_r;
    side5.item = it4_r;
  end

  srt_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_rad    (rad5),
    .in_side   (side5),
    .out_valid (sv),
    .out_root  (root),
    .out_side  (sside)
  );

  // Cosine used by the Schlick term.
  assign kk = coef.ext_gt ? $signed({2'b00, root}) : 27'(sside.c);
  assign xs = 27'sd16777216 - kk;

  // Refraction products and reflectance powers.
  assign pnx = $signed(it6_r.norm_x) * coef6_r;
  assign pny = $signed(it6_r.norm_y) * coef6_r;
  assign pnz = $signed(it6_r.norm_z) * coef6_r;
  assign pdx = ratio_s * $signed(it6_r.dir_x);
  assign pdy = ratio_s * $signed(it6_r.dir_y);
  assign pdz = ratio_s * $signed(it6_r.dir_z);
  assign x2p = 52'(x6_r) * 52'(x6_r);

  assign accx = 48'(pnx7_r) + 48'(pdx7_r) + 48'sd8388608;
  assign accy = 48'(pny7_r) + 48'(pdy7_r) + 48'sd8388608;
  assign accz = 48'(pnz7_r) + 48'(pdz7_r) + 48'sd8388608;
  assign x4p  = 54'(x2_7_r) * 54'(x2_7_r);
  assign x5p  = 55'(x4_8_r) * 55'(x8_r);
  assign om   = IONE - coef.r0;
  assign tp   = 55'(om) * 55'(x5_9_r);

  // Final blend and rounding to Q1.14.
  always_comb begin
    rr   = 32'(coef.r0) + 32'(t10_r) + 32'd512;
    rq   = rr[31:10];
    refl = (rq > 22'(REFL_ONE)) ? REFL_ONE : rq[14:0];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r    <= q_data;
      px1_r    <= px;
      py1_r    <= py;
      pz1_r    <= pz;
      it2_r    <= it1_r;
      c2_r     <= c_nxt;
      it3_r    <= it2_r;
      c3_r     <= c2_r;
      cos2_3_r <= cc[48:24];
      rc3_r    <= rcp[53:24];
      it4_r    <= it3_r;
      c4_r     <= c3_r;
      rc4_r    <= rc3_r;
      sin2_4_r <= sp[57:24];
      it6_r    <= sside.item;
      tir6_r   <= sside.tir;
      coef6_r  <= 31'(sside.rc) - $signed({6'd0, root});
      x6_r     <= xs[25:0];
      pnx7_r   <= pnx;
      pny7_r   <= pny;
      pnz7_r   <= pnz;
      pdx7_r   <= pdx;
      pdy7_r   <= pdy;
      pdz7_r   <= pdz;
      x2_7_r   <= x2p[50:24];
      x7_r     <= x6_r;
      tir7_r   <= tir6_r;
      rx8_r    <= sat16(accx[47:24]);
      ry8_r    <= sat16(accy[47:24]);
      rz8_r    <= sat16(accz[47:24]);
      x4_8_r   <= x4p[52:24];
      x8_r     <= x7_r;
      tir8_r   <= tir7_r;
      x5_9_r   <= x5p[53:24];
      rx9_r    <= rx8_r;
      ry9_r    <= ry8_r;
      rz9_r    <= rz8_r;
      tir9_r   <= tir8_r;
      t10_r    <= tp[54:24];
      rx10_r   <= rx9_r;
      ry10_r   <= ry9_r;
      rz10_r   <= rz9_r;
      tir10_r  <= tir9_r;
      if (tir10_r) begin
        out_r.refr_x        <= '0;
        out_r.refr_y        <= '0;
        out_r.refr_z        <= '0;
        out_r.total_reflect <= 1'b1;
        out_r.reflectance   <= REFL_ONE;
      end else begin
        out_r.refr_x        <= rx10_r;
        out_r.refr_y        <= ry10_r;
        out_r.refr_z        <= rz10_r;
        out_r.total_reflect <= 1'b0;
        out_r.reflectance   <= refl;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= q_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v6_r  <= sv;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      vo_r  <= v10_r;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/snell_refraction_schlick.sv
// Top level of the Snell refraction / Schlick reflectance block.
// Depends on srt_pkg, srt_if, srt_front, srt_sqrt and srt_back.
//
// Each request carries an incident direction and a unit normal (Q2.14) and
// yields one result: the refracted direction, a total internal reflection
// flag and the Schlick reflectance (Q1.14). The block takes one request per
// cycle while its result register is not stalled and returns results in
// order, through the 25-stage square root pipeline and the chain of
// reflectance multiplies. After reset and after every index register write,
// the quotient unit runs through a load step, 40 quotient bits and a
// multiply step, during which in_chan.ready is low. A full result
// register stalls the whole pipeline; the two-entry request queue keeps the
// input side taking up to two more requests meanwhile.
`default_nettype none

module snell_refraction_schlick import srt_pkg::*; #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  srt_in_if.sink      in_chan,
  srt_out_if.source   out_chan
);

  logic     q_valid, q_pop;
  in_item_t q_data;
  coef_t    coef;

  srt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_data   (in_chan.data),
    .in_ready  (in_chan.ready),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .coef      (coef)
  );

  srt_back #(
    .VEC_FRAC_BITS (VEC_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data),
    .out_ready (out_chan.ready)
  );

endmodule

`default_nettype wire

// File: bench/srt_refraction_checker.sv
// Scoreboard for the Snell refraction / Schlick reflectance block.
// Depends on srt_pkg and srt_if; watches the request and result channels.
`timescale 1ns / 100ps

module srt_refraction_checker import srt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          pending_count
);

  localparam int FB = 14;
  localparam longint ONE_Q24 = 64'sd1 << 24;

  logic [15:0] outside_idx;
  logic [15:0] inside_idx;
  out_item_t   expected_refr[$];

  // Floor shift right for signed values.
  function automatic longint fshr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint qm(longint a, longint b);
    return fshr(a * b, 24);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Computes the refracted direction and reflectance of one ray hit.
  function automatic out_item_t refract_hit(in_item_t it, logic [15:0] ext_i,
                                            logic [15:0] int_i);
    out_item_t o;
    longint d[3], n[3];
    longint dotp, c, ratio, cos2, sin2, cost, coef, q, r0, k, x, x2, x4, x5, rr, acc;
    longint unsigned ext, inn, diff, refl;
    ext = ext_i;
    inn = (int_i == 0) ? 1 : int_i;
    d[0] = it.dir_x;  d[1] = it.dir_y;  d[2] = it.dir_z;
    n[0] = it.norm_x; n[1] = it.norm_y; n[2] = it.norm_z;
    dotp = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    c = fshr(-dotp, 2 * FB - 24);
    if (c > ONE_Q24) c = ONE_Q24;
    if (c < -ONE_Q24) c = -ONE_Q24;
    ratio = longint'((ext << 24) / inn);
    if (ratio > (64'sd16 << 24)) ratio = 64'sd16 << 24;
    cos2 = qm(c, c);
    sin2 = qm(qm(ratio, ratio), ONE_Q24 - cos2);
    o = '0;
    if (sin2 > ONE_Q24) begin
      o.total_reflect = 1'b1;
      o.reflectance = REFL_ONE;
      return o;
    end
    cost = root_floor(longint'(ONE_Q24 - sin2) << 24);
    coef = qm(ratio, c) - cost;
    acc = n[0] * coef + ratio * d[0];
    o.refr_x = clip16(fshr(acc + (64'sd1 << 23), 24));
    acc = n[1] * coef + ratio * d[1];
    o.refr_y = clip16(fshr(acc + (64'sd1 << 23), 24));
    acc = n[2] * coef + ratio * d[2];
    o.refr_z = clip16(fshr(acc + (64'sd1 << 23), 24));
    diff = (ext > inn) ? ext - inn : inn - ext;
    q = longint'((diff << 24) / (ext + inn));
    r0 = qm(q, q);
    k = (ext > inn) ? cost : c;
    x = ONE_Q24 - k;
    x2 = qm(x, x);
    x4 = qm(x2, x2);
    x5 = qm(x4, x);
    rr = r0 + qm(ONE_Q24 - r0, x5);
    refl = (longint'(rr) + (64'd1 << 9)) >> 10;
    if (refl > 16384) refl = 16384;
    o.reflectance = refl[14:0];
    return o;
  endfunction

  assign pending_count = expected_refr.size();

  // Track registers, predict on each request, compare each result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      outside_idx <= OUTSIDE_RESET;
      inside_idx <= INSIDE_RESET;
      fail_count <= 0;
      expected_refr.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OUTSIDE) outside_idx <= cfg_wdata;
        else inside_idx <= cfg_wdata;
      end
      if (in_valid && in_ready)
        expected_refr.push_back(refract_hit(in_data, outside_idx, inside_idx));
      if (out_valid && out_ready) begin
        if (expected_refr.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_refr.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d tir=%0b r=%0d", $time,
                     want.refr_x, want.refr_y, want.refr_z, want.total_reflect,
                     want.reflectance);
            $display("%0t:          actual   x=%0d y=%0d z=%0d tir=%0b r=%0d", $time,
                     out_data.refr_x, out_data.refr_y, out_data.refr_z,
                     out_data.total_reflect, out_data.reflectance);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_snell_refraction_schlick.sv
// Stimulus and verdict for the Snell refraction / Schlick reflectance block.
// Depends on srt_pkg, srt_if, the block and srt_refraction_checker.
`timescale 1ns / 100ps

module tb_snell_refraction_schlick;
  import srt_pkg::*;

  localparam int CYCLE_LIMIT = 900000;
  localparam logic signed [15:0] UNIT = 16'sd16384;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_OUTSIDE;
  logic [15:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  srt_in_if  in_chan ();
  srt_out_if out_chan ();

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  snell_refraction_schlick dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_chan(in_chan), .out_chan(out_chan)
  );

  srt_refraction_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .in_data(in_chan.data), .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .out_data(out_chan.data), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // Receiver stalls at the phase's rate.
  always @(posedge clk)
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("snell_refraction_schlick regression: fail");
      $finish;
    end
  end

  // Drives one request and holds it until accepted. Valid stays high after
  // the accepting edge so that a following request can go back to back.
  task automatic send_hit(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic write_index(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384);
      2: return 16'($urandom_range(1) ? 32767 : -32768);
      default: return 16'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  // Mostly near-unit vectors with an opposing normal, plus raw noise.
  function automatic in_item_t rnd_hit();
    in_item_t it;
    it.dir_x = rnd_comp(); it.dir_y = rnd_comp(); it.dir_z = rnd_comp();
    if ($urandom_range(3) == 0) begin
      it.norm_x = rnd_comp(); it.norm_y = rnd_comp(); it.norm_z = rnd_comp();
    end else begin
      it.dir_x = 16'($signed($urandom_range(23000)) - 11500);
      it.dir_y = 16'($signed($urandom_range(23000)) - 11500);
      it.dir_z = -16'sd9000 - 16'($urandom_range(7000));
      it.norm_x = 16'($signed($urandom_range(2000)) - 1000);
      it.norm_y = 16'($signed($urandom_range(2000)) - 1000);
      it.norm_z = UNIT - 16'($urandom_range(300));
    end
    return it;
  endfunction

  function automatic in_item_t mk(int dx, int dy, int dz, int nx, int ny, int nz);
    in_item_t it;
    it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
    it.norm_x = 16'(nx); it.norm_y = 16'(ny); it.norm_z = 16'(nz);
    return it;
  endfunction

  initial begin
    logic [15:0] idx_pairs[8][2];
    idx_pairs = '{'{4096, 6144}, '{6144, 4096}, '{4096, 4096}, '{65535, 4096},
                  '{4096, 65535}, '{65535, 65535}, '{8000, 5461}, '{5000, 12000}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: normal incidence, grazing, extremes, non-unit, total reflection.
    send_hit(mk(0, 0, -16384, 0, 0, 16384));
    send_hit(mk(16384, 0, 0, 0, 0, 16384));
    send_hit(mk(11585, 0, -11585, 0, 0, 16384));
    send_hit(mk(32767, 32767, 32767, -32768, -32768, -32768));
    send_hit(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    send_hit(mk(0, 0, 16384, 0, 0, 16384));
    send_hit(mk(0, 0, 0, 0, 0, 0));
    send_hit(mk(-1, -1, -1, 1, 1, 1));
    send_hit(mk(16000, 0, -3000, 0, 0, 16384));
    drain_results();
    write_index(REG_OUTSIDE, 16'd6144);
    write_index(REG_INSIDE, 16'd4096);
    send_hit(mk(16000, 0, -3000, 0, 0, 16384));
    send_hit(mk(5000, 0, -15600, 0, 0, 16384));
    send_hit(mk(0, 0, -16384, 0, 0, 16384));
    drain_results();

    // Random phases across index settings and idling patterns.
    for (int ph = 0; ph < 16; ph++) begin
      write_index(REG_OUTSIDE, idx_pairs[ph % 8][0]);
      write_index(REG_INSIDE, idx_pairs[ph % 8][1]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (100) send_hit(rnd_hit());
      drain_results();
    end

    if (fail_count == 0)
      $display("snell_refraction_schlick regression: pass");
    else
      $display("snell_refraction_schlick regression: fail");
    $finish;
  end

endmodule
